[hw/rtl/tep_pkg.sv]
// Shared types, constants and month tables for the timestamp-to-epoch converter.
// No dependencies; the stage modules, the top level and the testbench import this package.
package tep_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FIELD = 2'd1,
    ST_EARLY     = 2'd2
  } tep_status_e;

  localparam logic [13:0] EPOCH_YEAR   = 14'd1970;
  localparam logic [13:0] RECIP25      = 14'd5243;   // 2^17 / 25, rounded up
  localparam logic [8:0]  LEAPS_1969   = 9'd477;     // leap years in [1, 1969]
  localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
  localparam logic [26:0] MS_PER_DAY   = 27'd86400000;
  localparam logic [21:0] MS_PER_HOUR  = 22'd3600000;
  localparam logic [15:0] MS_PER_MIN   = 16'd60000;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

  // Decoded input request.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  millisecond;
    logic [4:0]  digits_present;
  } tep_req_t;

  // After the field checks and the divide-by-25 products.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  millisecond;
    logic [7:0]  q100;       // (year / 4) / 25
    logic [5:0]  q400;       // (year / 16) / 25
    logic        bad;
    logic        early;
    logic        over_len;
    logic        feb29;
  } tep_s1_t;

  // Day count and time of day.
  typedef struct packed {
    logic [22:0] days;
    logic [26:0] tod;
    tep_status_e status;
    logic        warn;
  } tep_s2_t;

  // Day count scaled to milliseconds.
  typedef struct packed {
    logic [49:0] prod;
    logic [26:0] tod;
    tep_status_e status;
    logic        warn;
  } tep_s3_t;

  // Final result.
  typedef struct packed {
    logic [47:0] epoch_ms;
    tep_status_e status;
    logic        day_warning;
  } tep_res_t;

  // Stage handshake between pipeline modules.
  typedef struct packed {
    logic en;
    logic valid;
  } tep_ctl_t;

  // Length of a month, February counted as 28 days.
  function automatic logic [4:0] tep_month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of a month, non-leap year.
  function automatic logic [8:0] tep_days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/tep_req_if.sv]
// Request channel of the timestamp converter: valid/ready plus decoded fields.
// No dependencies.
interface tep_req_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [6:0]  month;
  logic [6:0]  day;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  logic [9:0]  millisecond;
  logic [4:0]  digits_present;

  modport source (
    output valid, year, month, day, hour, minute, second, millisecond, digits_present,
    input  ready
  );
  modport sink (
    input  valid, year, month, day, hour, minute, second, millisecond, digits_present,
    output ready
  );
endinterface

[hw/rtl/tep_res_if.sv]
// Result channel of the timestamp converter: valid/ready plus epoch and status.
// No dependencies.
interface tep_res_if;
  logic        valid;
  logic        ready;
  logic [47:0] epoch_ms;
  logic [1:0]  status;
  logic        day_warning;

  modport source (
    output valid, epoch_ms, status, day_warning,
    input  ready
  );
  modport sink (
    input  valid, epoch_ms, status, day_warning,
    output ready
  );
endinterface

[hw/rtl/tep_front.sv]
// Stage 1: field range checks, month-length check and year / 100, year / 400 parts.
// Depends on tep_pkg.
module tep_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tep_pkg::tep_ctl_t ctl_i,
  input  tep_pkg::tep_req_t req_i,
  output logic              valid_o,
  output tep_pkg::tep_s1_t  data_o
);
  import tep_pkg::*;

  logic        valid_q;
  tep_s1_t     data_q, data_d;
  logic [11:0] quarter;
  logic [9:0]  sixteenth;
  logic [25:0] prod_a;
  logic [23:0] prod_b;
  logic        month_ok;
  logic [3:0]  m4;
  logic [4:0]  mlen;

  // Divide by 25 through a reciprocal multiply; exact for these operand widths.
  assign quarter   = req_i.year[13:2];
  assign sixteenth = req_i.year[13:4];
  assign prod_a    = 26'(quarter) * 26'(RECIP25);
  assign prod_b    = 24'(sixteenth) * 24'(RECIP25);

  assign month_ok = (req_i.month != 7'd0) && (req_i.month <= 7'd12);
  assign m4       = req_i.month[3:0];
  assign mlen     = tep_month_len(m4);

  // Build the stage word.
  always_comb begin
    data_d.year        = req_i.year;
    data_d.month       = m4;
    data_d.day         = req_i.day;
    data_d.hour        = req_i.hour;
    data_d.minute      = req_i.minute;
    data_d.second      = req_i.second;
    data_d.millisecond = req_i.millisecond;
    data_d.q100        = prod_a[24:17];
    data_d.q400        = prod_b[22:17];
    data_d.bad = !month_ok
              || !req_i.digits_present[0] || (req_i.day == 7'd0)
              || !req_i.digits_present[1] || (req_i.hour > 7'd23)
              || !req_i.digits_present[2] || (req_i.minute > 7'd59)
              || !req_i.digits_present[3] || (req_i.second > 7'd59)
              || !req_i.digits_present[4] || (req_i.millisecond > 10'd999);
    data_d.early    = req_i.year < EPOCH_YEAR;
    data_d.over_len = (m4 == 4'd2) ? (req_i.day > 7'd29) : (req_i.day > 7'(mlen));
    data_d.feb29    = (m4 == 4'd2) && (req_i.day == 7'd29);
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

[hw/rtl/tep_days.sv]
// Stage 2: leap-year test, day count since the epoch and time of day in milliseconds.
// Depends on tep_pkg.
module tep_days (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tep_pkg::tep_ctl_t ctl_i,
  input  tep_pkg::tep_s1_t  s1_i,
  output logic              valid_o,
  output tep_pkg::tep_s2_t  data_o
);
  import tep_pkg::*;

  logic        valid_q;
  tep_s2_t     data_q, data_d;
  logic [11:0] quarter;
  logic [9:0]  sixteenth;
  logic        div4, cent, quad;
  logic        leap;
  logic [13:0] yoff;
  logic [22:0] ydays, leapcnt;

  assign quarter   = s1_i.year[13:2];
  assign sixteenth = s1_i.year[13:4];

  // Gregorian leap rule from the divide-by-25 quotients.
  assign div4 = s1_i.year[1:0] == 2'd0;
  assign cent = div4 && (quarter == 12'(s1_i.q100) * 12'd25);
  assign quad = (s1_i.year[3:0] == 4'd0) && (sixteenth == 10'(s1_i.q400) * 10'd25);
  assign leap = div4 && (!cent || quad);

  // Whole years and the leap days in [1970, year - 1].
  assign yoff    = s1_i.year - EPOCH_YEAR;
  assign ydays   = 23'(yoff) * 23'(DAYS_PER_YR);
  assign leapcnt = 23'(quarter) - 23'(s1_i.q100) + 23'(s1_i.q400)
                 - 23'(leap) - 23'(LEAPS_1969);

  always_comb begin
    data_d.days = ydays + leapcnt + 23'(tep_days_before(s1_i.month))
                + 23'(leap && (s1_i.month > 4'd2)) + 23'(s1_i.day) - 23'd1;
    data_d.tod  = 27'(s1_i.hour)   * 27'(MS_PER_HOUR)
                + 27'(s1_i.minute) * 27'(MS_PER_MIN)
                + 27'(s1_i.second) * 27'(MS_PER_SEC)
                + 27'(s1_i.millisecond);
    if (s1_i.bad) begin
      data_d.status = ST_BAD_FIELD;
    end else if (s1_i.early) begin
      data_d.status = ST_EARLY;
    end else begin
      data_d.status = ST_OK;
    end
    data_d.warn = !s1_i.bad && !s1_i.early && (s1_i.over_len || (s1_i.feb29 && !leap));
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

[hw/rtl/tep_scale.sv]
// Stages 3 and 4: day count times milliseconds per day, then the sum, saturation and zeroing on error.
// Depends on tep_pkg.
module tep_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tep_pkg::tep_ctl_t ctl_i,
  input  tep_pkg::tep_s2_t  s2_i,
  output logic              valid_o,
  output tep_pkg::tep_res_t data_o
);
  import tep_pkg::*;

  logic        v3_q, v4_q;
  tep_s3_t     s3_q, s3_d;
  tep_res_t    res_q, res_d;
  logic [50:0] sum;

  // Stage 3: one 23 x 27 multiply.
  always_comb begin
    s3_d.prod   = 50'(s2_i.days) * 50'(MS_PER_DAY);
    s3_d.tod    = s2_i.tod;
    s3_d.status = s2_i.status;
    s3_d.warn   = s2_i.warn;
  end

  // Stage 4: add the time of day, clamp to 48 bits, zero on error.
  assign sum = 51'(s3_q.prod) + 51'(s3_q.tod);

  always_comb begin
    res_d.status      = s3_q.status;
    res_d.day_warning = s3_q.warn;
    if (s3_q.status != ST_OK) begin
      res_d.epoch_ms = '0;
    end else if (sum[50:48] != 3'd0) begin
      res_d.epoch_ms = '1;
    end else begin
      res_d.epoch_ms = sum[47:0];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (ctl_i.en) begin
      v3_q <= ctl_i.valid;
      v4_q <= v3_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      s3_q  <= s3_d;
      res_q <= res_d;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = res_q;
endmodule

[hw/rtl/timestamp_to_epoch_millis.sv]
// Top level of the civil date/time to epoch milliseconds converter.
// Depends on tep_pkg, tep_req_if, tep_res_if, tep_front, tep_days and tep_scale.
//
//   Port    Direction  Carries
//   req_i   in         decoded year, month, day, hour, minute, second, ms, digit mask
//   res_o   out        epoch_ms, status, day_warning
//
// One request enters per cycle while the pipeline is not held.
// The four register stages (checks, day count, day multiply, sum) advance together.
// When a result waits at res_o, the whole pipeline holds and req_i.ready drops.
// Reset clears the stage valid bits only; no state lives between requests.
module timestamp_to_epoch_millis (
  input  logic  clk_i,
  input  logic  rst_ni,
  tep_req_if.sink   req_i,
  tep_res_if.source res_o
);
  import tep_pkg::*;

  logic     adv;
  logic     v1, v2, v4;
  tep_ctl_t ctl0, ctl1, ctl2;
  tep_req_t req;
  tep_s1_t  s1;
  tep_s2_t  s2;
  tep_res_t res;

  // The pipeline moves whenever the output register is free or being drained.
  assign adv         = !v4 || res_o.ready;
  assign req_i.ready = adv;

  assign ctl0 = '{en: adv, valid: req_i.valid};
  assign ctl1 = '{en: adv, valid: v1};
  assign ctl2 = '{en: adv, valid: v2};

  always_comb begin
    req.year           = req_i.year;
    req.month          = req_i.month;
    req.day            = req_i.day;
    req.hour           = req_i.hour;
    req.minute         = req_i.minute;
    req.second         = req_i.second;
    req.millisecond    = req_i.millisecond;
    req.digits_present = req_i.digits_present;
  end

  tep_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl0),
    .req_i   (req),
    .valid_o (v1),
    .data_o  (s1)
  );

  tep_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl1),
    .s1_i    (s1),
    .valid_o (v2),
    .data_o  (s2)
  );

  tep_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl2),
    .s2_i    (s2),
    .valid_o (v4),
    .data_o  (res)
  );

  assign res_o.valid       = v4;
  assign res_o.epoch_ms    = res.epoch_ms;
  assign res_o.status      = res.status;
  assign res_o.day_warning = res.day_warning;

  // A rejected request always reports a zero epoch value.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status != ST_OK)) |-> (res_o.epoch_ms == 48'd0))
    else $error("nonzero epoch on a rejected request");

  // The day warning only accompanies a converted value.
  a_warn_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.day_warning) |-> (res_o.status == ST_OK))
    else $error("day warning on a rejected request");

  // While the output is held, no stage valid bit may change.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(v1) && $stable(v2) && $stable(v4)))
    else $error("pipeline moved during a stall");

  // Status never carries the unused code.
  a_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.status != 2'd3))
    else $error("undefined status code");
endmodule

[test/tep_epoch_checker.sv]
`timescale 1ns / 1ps
// Watches the request and result channels of timestamp_to_epoch_millis and predicts every result.
// Depends on tep_pkg, tep_req_if and tep_res_if; reports a failure count and a pending count.
module tep_epoch_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tep_req_if   req_i,
  tep_res_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);
  import tep_pkg::*;

  localparam longint unsigned EPOCH_MS_MAX = 64'h0000_FFFF_FFFF_FFFF;

  // Results predicted for accepted requests, oldest first.
  tep_res_t expected_epochs[$];
  int       mismatches = 0;

  // Days in month m, with February following the leap flag.
  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    int unsigned len;
    case (m)
      2:            len = leap ? 29 : 28;
      4, 6, 9, 11:  len = 30;
      default:      len = 31;
    endcase
    return len;
  endfunction

  // Gregorian leap years in the range [1, y].
  function automatic longint unsigned leaps_through(input longint unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Expected result of one request: field checks first, then the year, then the sum.
  function automatic tep_res_t predict_epoch(input tep_req_t r);
    tep_res_t          res;
    longint unsigned   y;
    longint unsigned   day_count;
    longint unsigned   ms_total;
    bit                leap;
    res.epoch_ms    = '0;
    res.status      = ST_OK;
    res.day_warning = 1'b0;
    if (r.month == 0 || r.month > 12 || r.day == 0 || r.hour > 23 || r.minute > 59 ||
        r.second > 59 || r.millisecond > 999 || r.digits_present != 5'h1f) begin
      res.status = ST_BAD_FIELD;
      return res;
    end
    if (r.year < 1970) begin
      res.status = ST_EARLY;
      return res;
    end
    y    = r.year;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    res.day_warning = (r.day > days_in_month(r.month, leap));
    // Whole days since the epoch; extra days past the month end simply run on.
    day_count = (y - 1970) * 365 + leaps_through(y - 1) - leaps_through(1969) + (r.day - 1);
    for (int unsigned m = 1; m < r.month; m++) begin
      day_count += days_in_month(m, leap);
    end
    ms_total = day_count * 64'd86400000 + longint'(r.hour) * 3600000 +
               longint'(r.minute) * 60000 + longint'(r.second) * 1000 +
               longint'(r.millisecond);
    // Far-future years clip at the top of the 48-bit range.
    if (ms_total > EPOCH_MS_MAX) begin
      ms_total = EPOCH_MS_MAX;
    end
    res.epoch_ms = ms_total[47:0];
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on each accepted request and compare on each accepted result.
  always @(posedge clk_i) begin : watch
    tep_req_t req;
    tep_res_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        req = {req_i.year, req_i.month, req_i.day, req_i.hour, req_i.minute,
               req_i.second, req_i.millisecond, req_i.digits_present};
        expected_epochs.push_back(predict_epoch(req));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_epochs.size() == 0) begin
          $error("result with no request outstanding: epoch_ms %0d, status %0d",
                 res_i.epoch_ms, res_i.status);
          mismatches++;
        end else begin
          want = expected_epochs.pop_front();
          check_field("epoch_ms", want.epoch_ms, res_i.epoch_ms);
          check_field("status", 48'(want.status), 48'(res_i.status));
          check_field("day_warning", 48'(want.day_warning), 48'(res_i.day_warning));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_epochs.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Top of the timestamp_to_epoch_millis testbench: clock, reset, request stimulus and verdict.
// Depends on tep_pkg, both channel interfaces, the block itself and tep_epoch_checker.
module tb_top;
  import tep_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 560;

  logic        clk_i;
  logic        rst_ni;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int          fail_count;
  int          pending_count;

  tep_req_if req_if ();
  tep_res_if res_if ();

  timestamp_to_epoch_millis i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  tep_epoch_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The result side stalls at random at the rate of the current phase.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Safety net against a hung handshake.
  initial begin
    #(2_000_000);
    $display("timestamp_to_epoch_millis: mismatch");
    $finish;
  end

  function automatic tep_req_t make_request(input int y, input int mo, input int d,
                                            input int h, input int mi, input int s,
                                            input int ms, input int mask);
    tep_req_t r;
    r.year           = 14'(y);
    r.month          = 7'(mo);
    r.day            = 7'(d);
    r.hour           = 7'(h);
    r.minute         = 7'(mi);
    r.second         = 7'(s);
    r.millisecond    = 10'(ms);
    r.digits_present = 5'(mask);
    return r;
  endfunction

  // Mostly well-formed timestamps with random content, plus far-future years, days past
  // the month end, early years, broken fields and raw noise.
  function automatic tep_req_t random_request();
    tep_req_t    r;
    int unsigned kind;
    kind = $urandom_range(99);
    r = make_request($urandom_range(2200, 1970), $urandom_range(12, 1),
                     $urandom_range(28, 1), $urandom_range(23), $urandom_range(59),
                     $urandom_range(59), $urandom_range(999), 5'h1f);
    if (kind < 15) begin
      // Far future, up to the top of the year field where the value clips.
      r.year = 14'($urandom_range(16383, 1970));
    end else if (kind < 30) begin
      r.day = 7'($urandom_range(31, 29));
    end else if (kind < 38) begin
      r.day = 7'($urandom_range(127, 32));
    end else if (kind < 48) begin
      r.year = 14'($urandom_range(1969, 0));
    end else if (kind < 58) begin
      case ($urandom_range(6))
        0: r.month = $urandom_range(1) ? 7'd0 : 7'($urandom_range(127, 13));
        1: r.day = 7'd0;
        2: r.hour = 7'($urandom_range(127, 24));
        3: r.minute = 7'($urandom_range(127, 60));
        4: r.second = 7'($urandom_range(127, 60));
        5: r.millisecond = 10'($urandom_range(1023, 1000));
        default: r.digits_present = 5'($urandom_range(30));
      endcase
    end else if (kind < 66) begin
      r = tep_req_t'({$urandom, $urandom});
    end
    return r;
  endfunction

  // Offer one request, idling first at the sender's rate, and wait until it is taken.
  task automatic push_req(input tep_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.year           <= r.year;
    req_if.month          <= r.month;
    req_if.day            <= r.day;
    req_if.hour           <= r.hour;
    req_if.minute         <= r.minute;
    req_if.second         <= r.second;
    req_if.millisecond    <= r.millisecond;
    req_if.digits_present <= r.digits_present;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Lower valid and hold off until every outstanding request has its result.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni                = 1'b0;
    tx_idle_pct           = 20;
    rx_idle_pct           = 46;
    req_if.valid          <= 1'b0;
    req_if.year           <= '0;
    req_if.month          <= '0;
    req_if.day            <= '0;
    req_if.hour           <= '0;
    req_if.minute         <= '0;
    req_if.second         <= '0;
    req_if.millisecond    <= '0;
    req_if.digits_present <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: epoch start, early and far years, leap rules, month ends and field limits.
    push_req(make_request(1970, 1, 1, 0, 0, 0, 0, 31));
    push_req(make_request(1969, 12, 31, 23, 59, 59, 999, 31));
    push_req(make_request(0, 1, 1, 0, 0, 0, 0, 31));
    push_req(make_request(1900, 0, 1, 0, 0, 0, 0, 31));
    push_req(make_request(2038, 1, 19, 3, 14, 8, 0, 31));
    push_req(make_request(2000, 2, 29, 12, 0, 0, 0, 31));
    push_req(make_request(2100, 2, 29, 0, 0, 0, 0, 31));
    push_req(make_request(2023, 2, 29, 0, 0, 0, 0, 31));
    push_req(make_request(2024, 3, 1, 0, 0, 0, 0, 31));
    push_req(make_request(2023, 4, 31, 6, 7, 8, 9, 31));
    push_req(make_request(2024, 12, 127, 23, 59, 59, 999, 31));
    push_req(make_request(2024, 13, 1, 0, 0, 0, 0, 31));
    push_req(make_request(2024, 127, 1, 0, 0, 0, 0, 31));
    push_req(make_request(2024, 6, 0, 0, 0, 0, 0, 31));
    push_req(make_request(2024, 6, 15, 24, 0, 0, 0, 31));
    push_req(make_request(2024, 6, 15, 23, 60, 0, 0, 31));
    push_req(make_request(2024, 6, 15, 23, 59, 60, 0, 31));
    push_req(make_request(2024, 6, 15, 23, 59, 59, 1000, 31));
    push_req(make_request(2024, 6, 15, 23, 59, 59, 1023, 31));
    push_req(make_request(9999, 12, 31, 23, 59, 59, 999, 31));
    push_req(make_request(16383, 12, 31, 23, 59, 59, 999, 31));
    for (int b = 0; b < 5; b++) begin
      push_req(make_request(2024, 6, 15, 12, 30, 30, 500, 31 & ~(1 << b)));
    end

    // Random, sender idling less than the receiver.
    repeat (RANDOM_PER_PHASE) push_req(random_request());
    drain();

    // Random, receiver idling less than the sender.
    tx_idle_pct = 46;
    rx_idle_pct = 20;
    repeat (RANDOM_PER_PHASE) push_req(random_request());

    // Random at full rate on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) push_req(random_request());

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("timestamp_to_epoch_millis: match");
    end else begin
      $display("timestamp_to_epoch_millis: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tep_pkg.sv
hw/rtl/tep_req_if.sv
hw/rtl/tep_res_if.sv
hw/rtl/tep_front.sv
hw/rtl/tep_days.sv
hw/rtl/tep_scale.sv
hw/rtl/timestamp_to_epoch_millis.sv
test/tep_epoch_checker.sv
test/tb_top.sv
